// ===== rtl/rsch_pkg.sv =====
// Shared types and constants for the ray and sphere closest-hit unit.
// Holds the transaction structs, the sphere table entry, FSM states and datapath widths.
// No dependencies.
package rsch_pkg;

	localparam int MUL_W  = 68;
	localparam int PROD_W = 136;
	localparam int DIVN_W = 96;
	localparam int DIVD_W = 64;
	localparam int Q_W    = 32;
	localparam int ROOT_W = 68;
	localparam int HM_W   = 67;
	localparam int CM_W   = 66;
	localparam int RR_W   = 62;
	localparam int HH_W   = 134;
	localparam int AC_W   = 130;
	localparam int NUM_W  = 69;

	localparam logic [30:0] TMIN_RESET = 31'd66;
	localparam logic [30:0] TMAX_RESET = 31'h7FFF_FFFF;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_TRACE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		REG_COUNT = 2'd0,
		REG_TMIN  = 2'd1,
		REG_TMAX  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic               kind;
		logic [5:0]         slot;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic [30:0]        radius;
		logic [7:0]         material_in;
	} in_item_t;

	typedef struct packed {
		logic               hit;
		logic [30:0]        hit_t;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic               front_face;
		logic [7:0]         material_out;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic [30:0]        radius;
		logic [7:0]         material;
	} sphere_t;

	typedef enum logic {
		ITER_SQRT = 1'b0,
		ITER_DIV  = 1'b1
	} iter_op_t;

	typedef struct packed {
		logic     start;
		iter_op_t op;
	} iter_req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_AMUL,
		ST_RD,
		ST_LD,
		ST_HMUL,
		ST_OMUL,
		ST_RMUL,
		ST_CMP,
		ST_HH,
		ST_AC,
		ST_DISC,
		ST_SQRT,
		ST_NUM1,
		ST_DIV1,
		ST_NUM2,
		ST_DIV2,
		ST_FIN,
		ST_FLD,
		ST_PMUL,
		ST_PT,
		ST_DL,
		ST_NDIV,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/rsch_mul.sv =====
// Multi-cycle unsigned multiplier: 68 x 68 -> 136 bits from four 34 x 34 partial products.
// Each partial product is registered before it is accumulated. Uses rsch_pkg.
module rsch_mul
	import rsch_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MUL_W-1:0]  op_a,
	input  logic [MUL_W-1:0]  op_b,
	output logic              done,
	output logic [PROD_W-1:0] prod
);

	localparam int LIMB_W = MUL_W / 2;

	logic [MUL_W-1:0]    a_q;
	logic [MUL_W-1:0]    b_q;
	logic [1:0]          cnt_q;
	logic                issue_q;
	logic                pv_q;
	logic                done_q;
	logic [1:0]          psh_q;
	logic [2*LIMB_W-1:0] pp_q;
	logic [PROD_W-1:0]   acc_q;
	logic [LIMB_W-1:0]   limb_a;
	logic [LIMB_W-1:0]   limb_b;
	logic [PROD_W-1:0]   pp_ext;

	always_comb begin
		limb_a = cnt_q[1] ? a_q[MUL_W-1:LIMB_W] : a_q[LIMB_W-1:0];
		limb_b = cnt_q[0] ? b_q[MUL_W-1:LIMB_W] : b_q[LIMB_W-1:0];
		pp_ext = PROD_W'(pp_q) << (LIMB_W * psh_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			pv_q    <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			pv_q   <= issue_q;
			if (start) begin
				issue_q <= 1'b1;
				cnt_q   <= '0;
			end else if (issue_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3)
					issue_q <= 1'b0;
			end
			// last partial product lands this cycle
			if (pv_q && !issue_q)
				done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			b_q   <= op_b;
			acc_q <= '0;
		end else if (pv_q) begin
			acc_q <= acc_q + pp_ext;
		end
		if (issue_q) begin
			pp_q  <= limb_a * limb_b;
			psh_q <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== rtl/rsch_iter.sv =====
// Shared bit-serial unit: integer square root (two radicand bits per step) and
// quotient capped at 2^31 (one bit per step). Uses rsch_pkg.
module rsch_iter
	import rsch_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  iter_req_t         req,
	input  logic [PROD_W-1:0] radicand,
	input  logic [DIVN_W-1:0] dividend,
	input  logic [DIVD_W-1:0] divisor,
	output logic              done,
	output logic [ROOT_W-1:0] root,
	output logic [Q_W-1:0]    quot
);

	localparam int REM_W = ROOT_W + 4;

	logic              busy_q;
	logic              done_q;
	iter_op_t          op_q;
	logic [6:0]        cnt_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  rem2;
	logic [REM_W-1:0]  trial;
	logic [REM_W-1:0]  rem_sub;
	logic [PROD_W-1:0] sh_q;
	logic [ROOT_W-1:0] acc_q;
	logic [DIVD_W-1:0] dv_q;
	logic              cap;
	logic              ge;

	always_comb begin
		// any quotient of 2^31 or more saturates alike
		cap = dividend >= (DIVN_W'(divisor) << (Q_W - 1));
		if (op_q == ITER_SQRT) begin
			rem2  = {rem_q[REM_W-3:0], sh_q[PROD_W-1 -: 2]};
			trial = REM_W'({acc_q, 2'b01});
		end else begin
			rem2  = {rem_q[REM_W-2:0], sh_q[PROD_W-1]};
			trial = REM_W'(dv_q);
		end
		ge      = rem2 >= trial;
		rem_sub = rem2 - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= ITER_SQRT;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q <= req.op;
				if (req.op == ITER_DIV && cap) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= (req.op == ITER_SQRT) ? 7'(ROOT_W) : 7'(Q_W - 1);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= (req.op == ITER_DIV && cap) ? (ROOT_W'(1) << (Q_W - 1)) : '0;
			dv_q  <= divisor;
			if (req.op == ITER_SQRT) begin
				rem_q <= '0;
				sh_q  <= radicand;
			end else begin
				rem_q <= REM_W'(dividend >> (Q_W - 1));
				sh_q  <= PROD_W'(dividend[Q_W-2:0]) << (PROD_W - Q_W + 1);
			end
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub : rem2;
			acc_q <= {acc_q[ROOT_W-2:0], ge};
			sh_q  <= (op_q == ITER_SQRT) ? (sh_q << 2) : (sh_q << 1);
		end
	end

	assign done = done_q;
	assign root = acc_q;
	assign quot = acc_q[Q_W-1:0];

endmodule

// ===== rtl/ray_sphere_closest_hit_unit.sv =====
// Ray and sphere closest-hit unit. A trace tests the spheres in turn with the
// shared multiplier, the square root (68 steps) and the divider (31 steps); the
// final hit point and normal use the multiplier and the divider as well.
// One item is in work at a time. Reset clears control and configuration; the sphere
// table holds no reset value and reads undefined until a slot is loaded.
module ray_sphere_closest_hit_unit
	import rsch_pkg::*;
#(
	parameter int MAX_SPHERES = 64,
	parameter int FRAC_BITS   = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data
);

	localparam int IDX_W  = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
	localparam int CNT_W  = $clog2(MAX_SPHERES + 1);
	localparam int LOOP_W = (CNT_W > 7) ? CNT_W : 7;

	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		mag33 = v[32] ? 33'(-v) : 33'(v);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			sat32 = 32'h7FFF_FFFF;
		else if (v < -64'sd2147483648)
			sat32 = 32'h8000_0000;
		else
			sat32 = v[31:0];
	endfunction

	state_t state_q, state_d;
	logic   wait_q;
	logic   in_acc;
	logic   emit_ok;
	logic   mul_start;
	logic   mul_done;
	logic [PROD_W-1:0] prod;
	iter_req_t iter_req;
	logic   iter_done;
	logic [ROOT_W-1:0] root;
	logic [Q_W-1:0]    quot;
	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [DIVN_W-1:0] dividend;
	logic [DIVD_W-1:0] divisor;

	logic [6:0]  count_q;
	logic [30:0] tmin_q, tmax_q;

	sphere_t mem [MAX_SPHERES];
	sphere_t rd_q;
	sphere_t sph_q;
	logic [IDX_W-1:0] rd_addr;
	logic mem_we;

	logic signed [31:0] o_q [3];
	logic signed [31:0] d_q [3];
	logic signed [32:0] oc_q [3];
	logic signed [31:0] pt_q [3];
	logic signed [31:0] nrm_q [3];
	logic signed [31:0] ctr [3];
	logic [63:0]        a_q;
	logic [1:0]         k_q;
	logic [CNT_W-1:0]   i_q;
	logic [HM_W-1:0]    hp_q, hn_q, hm_q;
	logic [CM_W-1:0]    ocsq_q, cm_q;
	logic [RR_W-1:0]    rr_q;
	logic               hneg_q, cneg_q;
	logic [HH_W-1:0]    hh_q;
	logic [AC_W-1:0]    ac_q;
	logic [PROD_W-1:0]  disc_q;
	logic [ROOT_W-1:0]  s_q;
	logic [NUM_W-1:0]   num_q;
	logic [30:0]        closest_q, best_t_q;
	logic [IDX_W-1:0]   best_i_q;
	logic               best_front_q, any_q, res_hit_q;
	logic signed [63:0] dt_q;
	logic [32:0]        dm_q;
	logic               dneg_q;
	logic               out_valid_q;
	out_item_t          out_q, out_d;

	logic               in_loop;
	logic               t_ok;
	logic               dir_zero;
	logic signed [32:0] pc_diff;
	logic [32:0]        d_mag, oc_mag;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign emit_ok   = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		ctr[0]   = sph_q.cx;
		ctr[1]   = sph_q.cy;
		ctr[2]   = sph_q.cz;
		d_mag    = mag33(33'(d_q[k_q]));
		oc_mag   = mag33(oc_q[k_q]);
		pc_diff  = 33'(pt_q[k_q]) - 33'(ctr[k_q]);
		in_loop  = (LOOP_W'(i_q) < LOOP_W'(count_q)) && (LOOP_W'(i_q) < LOOP_W'(MAX_SPHERES));
		t_ok     = (quot > {1'b0, tmin_q}) && (quot < {1'b0, closest_q});
		dir_zero = (in_item.dir_x == 32'sd0) && (in_item.dir_y == 32'sd0)
			&& (in_item.dir_z == 32'sd0);
		mem_we   = in_acc && (in_item.kind == KIND_LOAD)
			&& ({26'd0, in_item.slot} < 32'(MAX_SPHERES));
		rd_addr  = (state_q == ST_FIN) ? best_i_q : i_q[IDX_W-1:0];
	end

	// sphere table
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[IDX_W'(in_item.slot)] <= '{cx: in_item.pos_x, cy: in_item.pos_y,
				cz: in_item.pos_z, radius: in_item.radius, material: in_item.material_in};
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_AMUL: begin
				mul_a = MUL_W'(d_mag);
				mul_b = MUL_W'(d_mag);
			end
			ST_HMUL: begin
				mul_a = MUL_W'(d_mag);
				mul_b = MUL_W'(oc_mag);
			end
			ST_OMUL: begin
				mul_a = MUL_W'(oc_mag);
				mul_b = MUL_W'(oc_mag);
			end
			ST_RMUL: begin
				mul_a = MUL_W'(sph_q.radius);
				mul_b = MUL_W'(sph_q.radius);
			end
			ST_HH: begin
				mul_a = MUL_W'(hm_q);
				mul_b = MUL_W'(hm_q);
			end
			ST_AC: begin
				mul_a = MUL_W'(a_q);
				mul_b = MUL_W'(cm_q);
			end
			ST_PMUL: begin
				mul_a = MUL_W'(d_mag);
				mul_b = MUL_W'(best_t_q);
			end
			default: ;
		endcase
		if (state_q == ST_NDIV) begin
			dividend = DIVN_W'(dm_q) << FRAC_BITS;
			divisor  = DIVD_W'(sph_q.radius);
		end else begin
			dividend = DIVN_W'(num_q) << FRAC_BITS;
			divisor  = a_q;
		end
	end

	rsch_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	rsch_iter u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (iter_req),
		.radicand (disc_q),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (iter_done),
		.root     (root),
		.quot     (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d        = state_q;
		mul_start      = 1'b0;
		iter_req.start = 1'b0;
		iter_req.op    = ITER_SQRT;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_item.kind == KIND_TRACE && !dir_zero)
						state_d = ST_AMUL;
					else
						state_d = ST_EMIT;
				end
			end
			ST_AMUL: begin
				mul_start = !wait_q;
				if (mul_done && k_q == 2'd2)
					state_d = ST_RD;
			end
			ST_RD: begin
				if (in_loop)
					state_d = ST_LD;
				else if (any_q)
					state_d = ST_FIN;
				else
					state_d = ST_EMIT;
			end
			ST_LD: state_d = (rd_q.radius == 31'd0) ? ST_RD : ST_HMUL;
			ST_HMUL: begin
				mul_start = !wait_q;
				if (mul_done)
					state_d = ST_OMUL;
			end
			ST_OMUL: begin
				mul_start = !wait_q;
				if (mul_done)
					state_d = (k_q == 2'd2) ? ST_RMUL : ST_HMUL;
			end
			ST_RMUL: begin
				mul_start = !wait_q;
				if (mul_done)
					state_d = ST_CMP;
			end
			ST_CMP: state_d = ST_HH;
			ST_HH: begin
				mul_start = !wait_q;
				if (mul_done)
					state_d = ST_AC;
			end
			ST_AC: begin
				mul_start = !wait_q;
				if (mul_done)
					state_d = ST_DISC;
			end
			ST_DISC: begin
				if (!cneg_q && (PROD_W'(hh_q) < PROD_W'(ac_q)))
					state_d = ST_RD;
				else
					state_d = ST_SQRT;
			end
			ST_SQRT: begin
				iter_req.start = !wait_q;
				iter_req.op    = ITER_SQRT;
				if (iter_done)
					state_d = ST_NUM1;
			end
			ST_NUM1: state_d = ST_DIV1;
			ST_DIV1: begin
				iter_req.start = !wait_q;
				iter_req.op    = ITER_DIV;
				if (iter_done)
					state_d = t_ok ? ST_RD : ST_NUM2;
			end
			ST_NUM2: state_d = ST_DIV2;
			ST_DIV2: begin
				iter_req.start = !wait_q;
				iter_req.op    = ITER_DIV;
				if (iter_done)
					state_d = ST_RD;
			end
			ST_FIN: state_d = ST_FLD;
			ST_FLD: state_d = ST_PMUL;
			ST_PMUL: begin
				mul_start = !wait_q;
				if (mul_done)
					state_d = ST_PT;
			end
			ST_PT: state_d = ST_DL;
			ST_DL: state_d = ST_NDIV;
			ST_NDIV: begin
				iter_req.start = !wait_q;
				iter_req.op    = ITER_DIV;
				if (iter_done)
					state_d = (k_q == 2'd2) ? ST_EMIT : ST_PMUL;
			end
			ST_EMIT: begin
				if (emit_ok)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q      <= 1'b0;
			count_q     <= '0;
			tmin_q      <= TMIN_RESET;
			tmax_q      <= TMAX_RESET;
			k_q         <= '0;
			i_q         <= '0;
			any_q       <= 1'b0;
			res_hit_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (mul_start || iter_req.start)
				wait_q <= 1'b1;
			else if (mul_done || iter_done)
				wait_q <= 1'b0;

			if (cfg_valid) begin
				case (reg_idx_t'(cfg_index))
					REG_COUNT: count_q <= cfg_data[6:0];
					REG_TMIN:  tmin_q  <= cfg_data;
					REG_TMAX:  tmax_q  <= cfg_data;
					default: ;
				endcase
			end

			if (state_q == ST_EMIT && emit_ok)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						k_q       <= '0;
						i_q       <= '0;
						any_q     <= 1'b0;
						res_hit_q <= 1'b0;
					end
				end
				ST_AMUL: begin
					if (mul_done)
						k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				end
				ST_LD: begin
					k_q <= '0;
					if (rd_q.radius == 31'd0)
						i_q <= i_q + 1'b1;
				end
				ST_OMUL: begin
					if (mul_done)
						k_q <= k_q + 2'd1;
				end
				ST_DISC: begin
					if (!cneg_q && (PROD_W'(hh_q) < PROD_W'(ac_q)))
						i_q <= i_q + 1'b1;
				end
				ST_DIV1: begin
					if (iter_done && t_ok) begin
						any_q <= 1'b1;
						i_q   <= i_q + 1'b1;
					end
				end
				ST_DIV2: begin
					if (iter_done) begin
						if (t_ok)
							any_q <= 1'b1;
						i_q <= i_q + 1'b1;
					end
				end
				ST_FLD: k_q <= '0;
				ST_NDIV: begin
					if (iter_done) begin
						k_q <= k_q + 2'd1;
						if (k_q == 2'd2)
							res_hit_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					o_q[0]    <= in_item.pos_x;
					o_q[1]    <= in_item.pos_y;
					o_q[2]    <= in_item.pos_z;
					d_q[0]    <= in_item.dir_x;
					d_q[1]    <= in_item.dir_y;
					d_q[2]    <= in_item.dir_z;
					a_q       <= '0;
					closest_q <= tmax_q;
				end
			end
			ST_AMUL: begin
				if (mul_done)
					a_q <= a_q + prod[63:0];
			end
			ST_LD: begin
				sph_q   <= rd_q;
				oc_q[0] <= 33'(rd_q.cx) - 33'(o_q[0]);
				oc_q[1] <= 33'(rd_q.cy) - 33'(o_q[1]);
				oc_q[2] <= 33'(rd_q.cz) - 33'(o_q[2]);
				hp_q    <= '0;
				hn_q    <= '0;
				ocsq_q  <= '0;
			end
			ST_HMUL: begin
				if (mul_done) begin
					if (oc_q[k_q][32] != d_q[k_q][31])
						hn_q <= hn_q + prod[HM_W-1:0];
					else
						hp_q <= hp_q + prod[HM_W-1:0];
				end
			end
			ST_OMUL: begin
				if (mul_done)
					ocsq_q <= ocsq_q + prod[CM_W-1:0];
			end
			ST_RMUL: begin
				if (mul_done)
					rr_q <= prod[RR_W-1:0];
			end
			ST_CMP: begin
				hneg_q <= hp_q < hn_q;
				hm_q   <= (hp_q < hn_q) ? hn_q - hp_q : hp_q - hn_q;
				cneg_q <= ocsq_q < CM_W'(rr_q);
				cm_q   <= (ocsq_q < CM_W'(rr_q)) ? CM_W'(rr_q) - ocsq_q : ocsq_q - CM_W'(rr_q);
			end
			ST_HH: begin
				if (mul_done)
					hh_q <= prod[HH_W-1:0];
			end
			ST_AC: begin
				if (mul_done)
					ac_q <= prod[AC_W-1:0];
			end
			ST_DISC: begin
				disc_q <= cneg_q ? PROD_W'(hh_q) + PROD_W'(ac_q)
					: PROD_W'(hh_q) - PROD_W'(ac_q);
			end
			ST_SQRT: begin
				if (iter_done)
					s_q <= root;
			end
			ST_NUM1: begin
				// near root, zero when it cannot be positive
				if (!hneg_q && (NUM_W'(hm_q) > NUM_W'(s_q)))
					num_q <= NUM_W'(hm_q) - NUM_W'(s_q);
				else
					num_q <= '0;
			end
			ST_DIV1: begin
				if (iter_done && t_ok) begin
					closest_q    <= quot[30:0];
					best_t_q     <= quot[30:0];
					best_i_q     <= i_q[IDX_W-1:0];
					best_front_q <= (s_q != '0);
				end
			end
			ST_NUM2: begin
				if (!hneg_q)
					num_q <= NUM_W'(hm_q) + NUM_W'(s_q);
				else if (NUM_W'(s_q) > NUM_W'(hm_q))
					num_q <= NUM_W'(s_q) - NUM_W'(hm_q);
				else
					num_q <= '0;
			end
			ST_DIV2: begin
				if (iter_done && t_ok) begin
					closest_q    <= quot[30:0];
					best_t_q     <= quot[30:0];
					best_i_q     <= i_q[IDX_W-1:0];
					best_front_q <= 1'b0;
				end
			end
			ST_FLD: sph_q <= rd_q;
			ST_PMUL: begin
				if (mul_done)
					dt_q <= d_q[k_q][31] ? 64'(-prod[63:0]) : prod[63:0];
			end
			ST_PT: pt_q[k_q] <= sat32(64'(o_q[k_q]) + (dt_q >>> FRAC_BITS));
			ST_DL: begin
				dm_q   <= mag33(pc_diff);
				dneg_q <= pc_diff[32];
			end
			ST_NDIV: begin
				if (iter_done) begin
					// quotient is capped at 2^31, so negation saturates by itself
					if (dneg_q ^ !best_front_q)
						nrm_q[k_q] <= 32'(-quot);
					else
						nrm_q[k_q] <= quot[31] ? 32'h7FFF_FFFF : quot;
				end
			end
			default: ;
		endcase

		if (state_q == ST_EMIT && emit_ok)
			out_q <= out_d;
	end

	always_comb begin
		out_d = '0;
		if (res_hit_q) begin
			out_d.hit          = 1'b1;
			out_d.hit_t        = best_t_q;
			out_d.point_x      = pt_q[0];
			out_d.point_y      = pt_q[1];
			out_d.point_z      = pt_q[2];
			out_d.normal_x     = nrm_q[0];
			out_d.normal_y     = nrm_q[1];
			out_d.normal_z     = nrm_q[2];
			out_d.front_face   = best_front_q;
			out_d.material_out = sph_q.material;
		end
	end

endmodule
